[src/cifd_pkg.sv]
`timescale 1ns / 1ps

package cifd_pkg;

  // Field widths fixed by the item format
  localparam int unsigned CountW    = 16;
  localparam int unsigned DecayW    = 8;
  localparam int unsigned RawW      = 16;
  localparam int unsigned HistOutW  = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DivisorW  = DecayW + 1;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_PASS_REQUIRED = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_DECAY_LEVEL   = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_TEMP_THRESH   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_VOLT_THRESH   = 8'd3;

  // Register reset values
  localparam logic [CountW-1:0]     PASS_REQUIRED_RST = 16'd1000;
  localparam logic [DecayW-1:0]     DECAY_LEVEL_RST   = 8'd0;
  localparam logic signed [RawW-1:0] TEMP_THRESH_RST  = 16'sd6400;
  localparam logic signed [RawW-1:0] VOLT_THRESH_RST  = 16'sd0;

  // Check interval after reset: 1000 / (0 + 1)
  localparam logic [CountW-1:0]     INTERVAL_RST      = 16'd1000;

  // Settings handed from the register file to the datapath
  typedef struct packed {
    logic [CountW-1:0]      interval;
    logic signed [RawW-1:0] temp_thresh;
    logic signed [RawW-1:0] volt_thresh;
  } cfg_t;

endpackage

[src/cifd_if.sv]
`timescale 1ns / 1ps

// One main-loop pass with its monitor readings
interface cifd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                charger_idle;
  logic signed [cifd_pkg::RawW-1:0]    temp_raw;
  logic                                temp_read_failed;
  logic signed [cifd_pkg::RawW-1:0]    volt_raw;
  logic                                volt_read_failed;

  modport source (
    output valid, charger_idle, temp_raw, temp_read_failed, volt_raw, volt_read_failed,
    input  ready
  );
  modport sink (
    input  valid, charger_idle, temp_raw, temp_read_failed, volt_raw, volt_read_failed,
    output ready
  );
endinterface

// Per-pass verdict
interface cifd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                restart_charger;
  logic                                read_error;
  logic                                safety_fault;
  logic [cifd_pkg::HistOutW-1:0]       idle_history_out;

  modport source (
    output valid, restart_charger, read_error, safety_fault, idle_history_out,
    input  ready
  );
  modport sink (
    input  valid, restart_charger, read_error, safety_fault, idle_history_out,
    output ready
  );
endinterface

// Register write channel
interface cifd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cifd_pkg::CfgIdxW-1:0]        index;
  logic [cifd_pkg::CfgDataW-1:0]       data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[src/cifd_divider.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module cifd_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [cifd_pkg::CountW-1:0]       dividend_i,
  input  logic [cifd_pkg::DivisorW-1:0]     divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [cifd_pkg::CountW-1:0]       quotient_o
);

  localparam int unsigned CntW = $clog2(cifd_pkg::CountW);
  localparam int unsigned RemW = cifd_pkg::DivisorW - 1;

  logic                              busy_q;
  logic [CntW-1:0]                   cnt_q;
  logic [cifd_pkg::CountW-1:0]       dvd_q;
  logic [RemW-1:0]                   rem_q;
  logic [cifd_pkg::DivisorW-1:0]     dvs_q;
  logic [cifd_pkg::DivisorW-1:0]     trial;
  logic [cifd_pkg::DivisorW-1:0]     diff;
  logic                              fits;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem_q, dvd_q[cifd_pkg::CountW-1]};
    fits  = trial >= dvs_q;
    diff  = trial - dvs_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(cifd_pkg::CountW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: shift quotient bits in as dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[cifd_pkg::CountW-2:0], fits};
      rem_q <= fits ? diff[RemW-1:0] : trial[RemW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = {dvd_q[cifd_pkg::CountW-2:0], fits};

  // The last step always ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !start_i |=> !busy_q)
    else $error("divider still busy after its last step");

endmodule

[src/cifd_core.sv]
`timescale 1ns / 1ps

// Input register, per-pass decision logic and result register
module cifd_core #(
  parameter int unsigned HistBits = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_en_i,
  input  cifd_pkg::cfg_t    cfg_i,
  cifd_in_if.sink           in_i,
  cifd_out_if.source        out_o
);

  // Input register
  logic                                in_vld_q;
  logic                                idle_q;
  logic signed [cifd_pkg::RawW-1:0]    temp_q;
  logic                                temp_fail_q;
  logic signed [cifd_pkg::RawW-1:0]    volt_q;
  logic                                volt_fail_q;

  // Loop state
  logic [cifd_pkg::CountW-1:0]         pass_cnt_q;
  logic [HistBits-1:0]                 hist_q;
  logic                                restarted_q;

  // Result register
  logic                                out_vld_q;
  logic                                restart_q;
  logic                                rerr_q;
  logic                                fault_q;
  logic [cifd_pkg::HistOutW-1:0]       hist_out_q;

  logic                                advance;
  logic                                in_xfer;
  logic                                out_xfer;
  logic                                checked;
  logic [HistBits-1:0]                 hist_shift;
  logic [HistBits-1:0]                 hist_d;
  logic [cifd_pkg::CountW-1:0]         pass_cnt_d;
  logic                                restarted_d;
  logic                                restart_d;
  logic                                rerr_d;
  logic                                fault_d;
  logic [cifd_pkg::HistOutW-1:0]       hist_view;

  // Handshakes
  assign advance   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = accept_en_i && (!in_vld_q || advance);
  assign in_xfer   = in_i.valid && in_i.ready;
  assign out_xfer  = out_o.valid && out_o.ready;

  // Decide one pass
  always_comb begin
    checked     = pass_cnt_q > cfg_i.interval;
    hist_shift  = {hist_q[HistBits-2:0], 1'b1};
    hist_d      = hist_q;
    pass_cnt_d  = pass_cnt_q + 1'b1;
    restarted_d = restarted_q;
    restart_d   = 1'b0;
    rerr_d      = 1'b0;
    fault_d     = 1'b0;
    if (checked) begin
      pass_cnt_d = '0;
      if (idle_q) begin
        hist_d = hist_shift;
        if (&hist_shift) begin
          if (!restarted_q) begin
            priority if (temp_fail_q || volt_fail_q) begin
              rerr_d = 1'b1;
            end else if (temp_q >= cfg_i.temp_thresh && volt_q >= cfg_i.volt_thresh) begin
              restart_d   = 1'b1;
              restarted_d = 1'b1;
            end else begin
              // readings below threshold: no request
              restart_d = 1'b0;
            end
          end else begin
            fault_d = 1'b1;
          end
        end
      end else begin
        hist_d      = '0;
        restarted_d = 1'b0;
      end
    end
  end

  // Low bits of the history as reported, zero above a short history
  for (genvar g = 0; g < int'(cifd_pkg::HistOutW); g++) begin : g_view
    if (g < int'(HistBits)) begin : g_bit
      assign hist_view[g] = hist_d[g];
    end else begin : g_pad
      assign hist_view[g] = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      pass_cnt_q  <= '0;
      hist_q      <= '0;
      restarted_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q   <= 1'b1;
        pass_cnt_q  <= pass_cnt_d;
        hist_q      <= hist_d;
        restarted_q <= restarted_d;
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idle_q      <= in_i.charger_idle;
      temp_q      <= in_i.temp_raw;
      temp_fail_q <= in_i.temp_read_failed;
      volt_q      <= in_i.volt_raw;
      volt_fail_q <= in_i.volt_read_failed;
    end
    if (advance) begin
      restart_q  <= restart_d;
      rerr_q     <= rerr_d;
      fault_q    <= fault_d;
      hist_out_q <= hist_view;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.restart_charger  = restart_q;
  assign out_o.read_error       = rerr_q;
  assign out_o.safety_fault     = fault_q;
  assign out_o.idle_history_out = hist_out_q;

  // At most one flag per verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $countones({restart_q, rerr_q, fault_q}) <= 1)
    else $error("more than one verdict flag set");

  // A restart request always leaves the restarted mark behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && restart_d |=> restarted_q)
    else $error("restart issued without marking it");

  // The restarted mark only changes when a pass is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(restarted_q) && $stable(hist_q))
    else $error("loop state moved without a pass");

endmodule

[src/chronic_idle_fault_detector.sv]
`timescale 1ns / 1ps

// Channel  Dir  Modport  Payload
// in_i     in   sink     charger_idle, temp_raw, temp_read_failed, volt_raw, volt_read_failed
// out_o    out  source   restart_charger, read_error, safety_fault, idle_history_out
// cfg_i    in   sink     index (register number), data
//
// A pass is taken into an input register and decided combinationally into the result
// register; a new pass is taken every cycle while out_o is not stalled and no recompute runs.
// A write to pass_required or the decay level recomputes the check interval in a
// bit-serial divider: in_i.ready is low while that recompute is pending or running.
// Reset clears the pass count, the idle history and the restarted mark.
// A stalled out_o holds its result while one more pass waits in the input register.
module chronic_idle_fault_detector #(
  parameter int unsigned HistBits = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cifd_in_if.sink      in_i,
  cifd_out_if.source   out_o,
  cifd_cfg_if.sink     cfg_i
);

  logic [cifd_pkg::CountW-1:0]        pass_req_q;
  logic [cifd_pkg::DecayW-1:0]        decay_q;
  logic signed [cifd_pkg::RawW-1:0]   temp_thr_q;
  logic signed [cifd_pkg::RawW-1:0]   volt_thr_q;
  logic [cifd_pkg::CountW-1:0]        interval_q;
  logic                               div_start_q;
  logic                               cfg_xfer;
  logic                               div_busy;
  logic                               div_done;
  logic [cifd_pkg::CountW-1:0]        quotient;
  logic [cifd_pkg::DivisorW-1:0]      divisor;
  cifd_pkg::cfg_t                     cfg;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;
  assign divisor     = {1'b0, decay_q} + 1'b1;

  // Register file and interval recompute trigger
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_req_q  <= cifd_pkg::PASS_REQUIRED_RST;
      decay_q     <= cifd_pkg::DECAY_LEVEL_RST;
      temp_thr_q  <= cifd_pkg::TEMP_THRESH_RST;
      volt_thr_q  <= cifd_pkg::VOLT_THRESH_RST;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_xfer) begin
        unique case (cfg_i.index)
          cifd_pkg::REG_PASS_REQUIRED: begin
            pass_req_q  <= cfg_i.data;
            div_start_q <= 1'b1;
          end
          cifd_pkg::REG_DECAY_LEVEL: begin
            decay_q     <= cfg_i.data[cifd_pkg::DecayW-1:0];
            div_start_q <= 1'b1;
          end
          cifd_pkg::REG_TEMP_THRESH: temp_thr_q <= cfg_i.data;
          cifd_pkg::REG_VOLT_THRESH: volt_thr_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // Latch the new interval when the divider finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= cifd_pkg::INTERVAL_RST;
    end else if (div_done) begin
      interval_q <= quotient;
    end
  end

  cifd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (pass_req_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign cfg.interval    = interval_q;
  assign cfg.temp_thresh = temp_thr_q;
  assign cfg.volt_thresh = volt_thr_q;

  cifd_core #(
    .HistBits (HistBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_en_i (!(div_start_q || div_busy)),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o)
  );

  // No pass is taken while the interval is being recomputed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_start_q || div_busy) |-> !in_i.ready)
    else $error("pass accepted during interval recompute");

  // The start pulse after a write to pass_required or the decay level always sets the divider busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |=> div_busy)
    else $error("interval recompute did not start");

endmodule
